// ----- rtl/omp_pkg.sv -----
// Shared types, constants and request codes of the ordered message pool.
`default_nettype none

package omp_pkg;

    localparam int POOL_DEPTH   = 16;
    localparam int HANDLE_WIDTH = 16;

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    localparam int REQ_W     = 3;
    localparam int UID_W     = 32;
    localparam int POS_W     = 4;
    localparam int OUT_PAY_W = 16;

    localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PEEK      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MARK_DONE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_MARK_NEW  = 3'd5;

    localparam logic KIND_PLAIN = 1'b1;

    typedef struct packed {
        logic [UID_W-1:0]        uid;
        logic                    plain;
        logic                    done;
        logic [HANDLE_WIDTH-1:0] payload;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     position;
        logic                 processed;
        logic [UID_W-1:0]     uid;
        logic                 is_plain;
        logic [OUT_PAY_W-1:0] payload;
        logic                 empty;
        logic                 dropped;
    } res_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [UID_W-1:0] uid;
        logic             resend;
    } match_ctl_t;

endpackage : omp_pkg

`default_nettype wire

// ----- rtl/omp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module omp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : omp_ram

`default_nettype wire

// ----- rtl/omp_match.sv -----
// Shared compare unit that decides whether one stored entry satisfies the request.
`default_nettype none

module omp_match
    import omp_pkg::*;
(
    input  wire match_ctl_t ctl,
    input  wire slot_t      slot,
    output logic            hit
);

    logic uid_eq;
    logic peek_ok;

    assign uid_eq  = (slot.uid == ctl.uid);
    assign peek_ok = ctl.resend || (slot.plain != KIND_PLAIN) || !slot.done;

    always_comb
    begin
        unique case (ctl.req)
            REQ_PEEK:      hit = peek_ok;
            REQ_REMOVE,
            REQ_LOOKUP,
            REQ_MARK_DONE,
            REQ_MARK_NEW:  hit = uid_eq;
            default:       hit = 1'b0;
        endcase
    end

endmodule : omp_match

`default_nettype wire

// ----- rtl/ordered_message_pool_core.sv -----
// Top level of the ordered message pool: request sequencer, entry RAM and result register.
`default_nettype none

// An ordered pool of up to 16 message entries, position 0 the oldest, served one request
// at a time. The entries live in one RAM with a registered read port, and a single compare
// unit walks them one entry per cycle, oldest first, so the RAM read port sets the rate.
// An append, an unused request code or any request to an empty pool goes straight from accept
// to the finish state; peek, lookup and the two mark requests scan until a hit or until the
// youngest entry; a remove adds the compaction that moves every younger entry one place down,
// and no entry moves when the removed entry is the youngest. The input is not ready while a
// request is in work, but a new request is taken while the previous result still waits on
// the output.

module ordered_message_pool_core
    import omp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [REQ_W-1:0]        req_type,
    input  wire logic signed [UID_W-1:0] msg_uid,
    input  wire logic                    is_plain_message,
    input  wire logic                    start_processed,
    input  wire logic [15:0]             payload_handle,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic                         entry_processed,
    output logic signed [UID_W-1:0]      entry_uid,
    output logic                         entry_is_plain,
    output logic [OUT_PAY_W-1:0]         entry_payload,
    output logic                         pool_empty,
    output logic                         append_dropped
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_MOVE   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             resend_reg,    resend_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic             pend_reg,      pend_next;
    logic [IDX_W-1:0] pend_idx_reg,  pend_idx_next;
    logic [CNT_W-1:0] src_reg,       src_next;
    logic [IDX_W-1:0] dst_reg,       dst_next;
    logic             out_valid_reg, out_valid_next;
    logic [REQ_W-1:0] req_reg,       req_next;
    logic [UID_W-1:0] uid_reg,       uid_next;
    res_t             res_reg,       res_next;
    res_t             out_reg,       out_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    slot_t            ram_wdata;
    slot_t            ram_rdata;
    logic             hit;
    match_ctl_t       match_ctl;
    res_t             res_idle;

    omp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign match_ctl = '{req: req_reg, uid: uid_reg, resend: resend_reg};

    omp_match u_match (
        .ctl  (match_ctl),
        .slot (ram_rdata),
        .hit  (hit)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        res_idle           = '0;
        res_idle.is_plain  = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        resend_next    = resend_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_next       = req_reg;
        uid_next       = uid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = dst_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg;

        if (cfg_valid && cfg_ready)
        begin
            resend_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    uid_next      = msg_uid;
                    res_next      = res_idle;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    state_next    = S_FINISH;
                    if (req_type == REQ_APPEND)
                    begin
                        if (count_reg == CNT_W'(POOL_DEPTH))
                        begin
                            res_next.dropped = 1'b1;
                        end
                        else
                        begin
                            ram_we            = 1'b1;
                            ram_waddr         = count_reg[IDX_W-1:0];
                            ram_wdata.uid     = msg_uid;
                            ram_wdata.plain   = is_plain_message;
                            ram_wdata.done    = start_processed;
                            ram_wdata.payload = HANDLE_WIDTH'(payload_handle);
                            count_next        = count_reg + CNT_W'(1);
                        end
                    end
                    else if ((req_type == REQ_PEEK) || (req_type == REQ_REMOVE) ||
                             (req_type == REQ_LOOKUP) || (req_type == REQ_MARK_DONE) ||
                             (req_type == REQ_MARK_NEW))
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ram_raddr = idx_reg;
                if (pend_reg && hit)
                begin
                    res_next.found     = 1'b1;
                    res_next.position  = POS_W'(pend_idx_reg);
                    res_next.processed = ram_rdata.done;
                    state_next         = S_FINISH;
                    if (req_reg == REQ_PEEK)
                    begin
                        res_next.uid      = ram_rdata.uid;
                        res_next.is_plain = ram_rdata.plain;
                        res_next.payload  = OUT_PAY_W'(ram_rdata.payload);
                    end
                    else if ((req_reg == REQ_MARK_DONE) || (req_reg == REQ_MARK_NEW))
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = pend_idx_reg;
                        ram_wdata.done     = (req_reg == REQ_MARK_DONE);
                        res_next.processed = (req_reg == REQ_MARK_DONE);
                    end
                    else if (req_reg == REQ_REMOVE)
                    begin
                        src_next   = CNT_W'(pend_idx_reg) + CNT_W'(1);
                        dst_next   = pend_idx_reg;
                        pend_next  = 1'b0;
                        state_next = S_MOVE;
                    end
                end
                else if (pend_reg && (CNT_W'(pend_idx_reg) == count_reg - CNT_W'(1)))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end

            S_MOVE:
            begin
                ram_raddr = src_reg[IDX_W-1:0];
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                    dst_next  = dst_reg + IDX_W'(1);
                end
                if (src_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    src_next  = src_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_next.empty = (count_reg == '0);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            resend_reg    <= 1'b1;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            resend_reg    <= resend_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        uid_reg <= uid_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign found           = out_reg.found;
    assign position        = out_reg.position;
    assign entry_processed = out_reg.processed;
    assign entry_uid       = out_reg.uid;
    assign entry_is_plain  = out_reg.is_plain;
    assign entry_payload   = out_reg.payload;
    assign pool_empty      = out_reg.empty;
    assign append_dropped  = out_reg.dropped;

`ifndef SYNTHESIS
    // The entry count never passes the pool depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_DEPTH))
        else $error("entry count exceeds pool depth");

    // During compaction with a read pending, the read pointer is always two places ahead of its write target.
    a_move_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) && pend_reg |-> (CNT_W'(dst_reg) + CNT_W'(2) == src_reg))
        else $error("compaction read and write pointers out of step");

    // A dropped append is only reported when the pool is full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && res_reg.dropped |-> (count_reg == CNT_W'(POOL_DEPTH)))
        else $error("append dropped while the pool had room");

    // A finished result enters the output register as soon as it is free.
    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && (!out_valid_reg || out_ready) |=>
            out_valid_reg && (state_reg == S_IDLE))
        else $error("finished result was not loaded into the output register");
`endif

endmodule : ordered_message_pool_core

`default_nettype wire
